// ----- rtl/core/emt_pkg.sv -----
// Shared widths, codes and command types for the encoder multi-turn position tracker.
`timescale 1ns / 1ps

package emt_pkg;

  localparam int RESP_W    = 16;
  localparam int ANG_W     = 12;
  localparam int TURN_W    = 24;
  localparam int MULTI_W   = TURN_W + ANG_W;
  localparam int POS_W     = 48;
  localparam int OFFS_W    = 41;
  localparam int MSTEP_W   = 9;
  localparam int STEPS_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = OFFS_W;
  localparam int STAT_W    = 2;

  localparam int COUNTS_PER_REV = 1 << ANG_W;
  localparam int HALF_REV       = COUNTS_PER_REV / 2;

  localparam int K_W     = MSTEP_W + STEPS_W;
  localparam int HALF_W  = MULTI_W / 2;
  localparam int PROD_W  = HALF_W + K_W;
  localparam int ACC_W   = MULTI_W + K_W;
  localparam int QUOT_W  = ACC_W - ANG_W;

  localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ERRFLG = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_PARITY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_STEPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd2;

  localparam logic [MSTEP_W-1:0] MSTEP_RST = 9'd8;
  localparam logic [STEPS_W-1:0] STEPS_RST = 11'd200;

  typedef struct packed {
    logic accept;
    logic load_mag;
    logic mul_lo;
    logic mul_hi;
    logic load_out;
  } emt_cmd_t;

endpackage

// ----- rtl/core/emt_ctrl.sv -----
// Sequencer for the tracker: input handshake, multiply steps and output register valid.
`timescale 1ns / 1ps

module emt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output emt_pkg::emt_cmd_t cmd_o
);
  import emt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAG,
    S_MUL_LO,
    S_MUL_HI,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.load_mag = (state_q == S_MAG);
    cmd_o.mul_lo   = (state_q == S_MUL_LO);
    cmd_o.mul_hi   = (state_q == S_MUL_HI);
    cmd_o.load_out = (state_q == S_FIN) && out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_MAG;
      S_MAG:    state_d = S_MUL_LO;
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_FIN;
      S_FIN:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_MAG))
    else $error("accepted item did not start the sequence");
  a_valid_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result valid without a finished item");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && out_valid_q && out_stall_i) |=> (state_q == S_FIN))
    else $error("finished item left while output was stalled");
`endif

endmodule

// ----- rtl/core/emt_dp.sv -----
// Datapath: reply check, turn tracking, scaling multiply and result registers.
`timescale 1ns / 1ps

module emt_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  emt_pkg::emt_cmd_t                   cmd_i,
  input  logic [emt_pkg::RESP_W-1:0]          response_word_i,
  input  logic                                cfg_we_i,
  input  logic [emt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [emt_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic [emt_pkg::STAT_W-1:0]          status_o,
  output logic [emt_pkg::ANG_W-1:0]           angle_count_o,
  output logic signed [emt_pkg::MULTI_W-1:0]  multi_turn_count_o,
  output logic signed [emt_pkg::POS_W-1:0]    motor_position_o
);
  import emt_pkg::*;

  logic [MSTEP_W-1:0] mstep_q;
  logic [STEPS_W-1:0] steps_q;
  logic [OFFS_W-1:0]  offs_q;

  logic [ANG_W-1:0]   last_q, last_d;
  logic [TURN_W-1:0]  turn_q, turn_d;
  logic [STAT_W-1:0]  stat_q, stat_d;

  logic [ANG_W-1:0]   angle;
  logic               par_bad;
  logic [ANG_W:0]     ang_x, last_x;

  logic [MULTI_W-1:0] multi;
  logic [MULTI_W-1:0] mag_q;
  logic               neg_q;
  logic [K_W-1:0]     k_q;
  logic [HALF_W-1:0]  mul_a;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [QUOT_W-1:0]  quot;
  logic [POS_W-1:0]   scaled, offs_x, pos;

  logic [STAT_W-1:0]  stat_out_q;
  logic [ANG_W-1:0]   ang_out_q;
  logic [MULTI_W-1:0] multi_out_q;
  logic [POS_W-1:0]   pos_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstep_q <= MSTEP_RST;
      steps_q <= STEPS_RST;
      offs_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MICROSTEPS:  mstep_q <= cfg_wdata_i[MSTEP_W-1:0];
        CFG_MOTOR_STEPS: steps_q <= cfg_wdata_i[STEPS_W-1:0];
        CFG_OFFSET:      offs_q  <= cfg_wdata_i[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // drop the low three angle bits, then double
  assign angle   = {response_word_i[13:3], 1'b0};
  assign par_bad = response_word_i[15] != (^response_word_i[14:0]);
  assign ang_x   = {1'b0, angle};
  assign last_x  = {1'b0, last_q};

  always_comb begin
    last_d = last_q;
    turn_d = turn_q;
    stat_d = stat_q;
    if (cmd_i.accept) begin
      if (response_word_i[14]) begin
        stat_d = STATUS_ERRFLG;
      end else if (par_bad) begin
        stat_d = STATUS_PARITY;
      end else begin
        stat_d = STATUS_OK;
        last_d = angle;
        if (ang_x + (ANG_W+1)'(HALF_REV) < last_x) begin
          turn_d = turn_q + TURN_W'(1);
        end else if (ang_x > last_x + (ANG_W+1)'(HALF_REV)) begin
          turn_d = turn_q - TURN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      turn_q <= '0;
      stat_q <= STATUS_OK;
    end else begin
      last_q <= last_d;
      turn_q <= turn_d;
      stat_q <= stat_d;
    end
  end

  assign multi = {turn_q, last_q};

  // shared multiplier: low half of magnitude first, then high half
  assign mul_a = cmd_i.mul_hi ? mag_q[MULTI_W-1:HALF_W] : mag_q[HALF_W-1:0];
  assign prod  = PROD_W'(mul_a) * PROD_W'(k_q);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul_lo) begin
      acc_d = ACC_W'(prod);
    end else if (cmd_i.mul_hi) begin
      acc_d = acc_q + (ACC_W'(prod) << HALF_W);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mag) begin
      neg_q <= multi[MULTI_W-1];
      mag_q <= multi[MULTI_W-1] ? (~multi + MULTI_W'(1)) : multi;
      k_q   <= K_W'(mstep_q) * K_W'(steps_q);
    end
    acc_q <= acc_d;
  end

  assign quot   = acc_q[ACC_W-1:ANG_W];
  assign scaled = neg_q ? (~POS_W'(quot) + POS_W'(1)) : POS_W'(quot);
  assign offs_x = POS_W'($signed(offs_q));
  assign pos    = scaled - offs_x;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      stat_out_q  <= stat_q;
      ang_out_q   <= last_q;
      multi_out_q <= multi;
      pos_out_q   <= pos;
    end
  end

  assign status_o           = stat_out_q;
  assign angle_count_o      = ang_out_q;
  assign multi_turn_count_o = $signed(multi_out_q);
  assign motor_position_o   = $signed(pos_out_q);

`ifndef ASSERT_OFF
  a_state_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.accept |=> ($stable(turn_q) && $stable(last_q)))
    else $error("turn state changed without an item");
  a_hold_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && response_word_i[14]) |=> ($stable(turn_q) && $stable(last_q)))
    else $error("turn state changed on a flagged reply");
  a_hold_on_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && !response_word_i[14] && par_bad)
      |=> ($stable(turn_q) && $stable(last_q)))
    else $error("turn state changed on a parity mismatch");
`endif

endmodule

// ----- rtl/core/encoder_multiturn_position_tracker.sv -----
// Top level of the encoder multi-turn position tracker.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------------
//  input    | in_valid_i / in_stall_o | response_word_i
//  output   | out_valid_o/out_stall_i | status_o, angle_count_o, multi_turn_count_o,
//           |                         | motor_position_o
//  config   | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// An item steps through accept, magnitude and gain, two multiply passes, result load.
// The 36x20 scaling multiply runs as two 18-bit passes through one multiplier.
// The next item is accepted the cycle after the result loads into the output register.
// A stalled output holds the finished item in the last step until the register frees.
// Reset clears the turn count and last angle and loads the register defaults.
`timescale 1ns / 1ps

module encoder_multiturn_position_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [emt_pkg::RESP_W-1:0]          response_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [emt_pkg::STAT_W-1:0]          status_o,
  output logic [emt_pkg::ANG_W-1:0]           angle_count_o,
  output logic signed [emt_pkg::MULTI_W-1:0]  multi_turn_count_o,
  output logic signed [emt_pkg::POS_W-1:0]    motor_position_o,
  input  logic                                cfg_we_i,
  input  logic [emt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [emt_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import emt_pkg::*;

  emt_cmd_t cmd;

  emt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  emt_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .response_word_i    (response_word_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .status_o           (status_o),
    .angle_count_o      (angle_count_o),
    .multi_turn_count_o (multi_turn_count_o),
    .motor_position_o   (motor_position_o)
  );

endmodule

// ----- verif/emt_position_checker.sv -----
// Scoreboard for the encoder multi-turn position tracker: predicts each result and compares it.
`timescale 1ns / 1ps

module emt_position_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [emt_pkg::RESP_W-1:0]          response_word_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [emt_pkg::STAT_W-1:0]          status_i,
  input  logic [emt_pkg::ANG_W-1:0]           angle_count_i,
  input  logic signed [emt_pkg::MULTI_W-1:0]  multi_turn_count_i,
  input  logic signed [emt_pkg::POS_W-1:0]    motor_position_i,
  input  logic                                cfg_we_i,
  input  logic [emt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [emt_pkg::CFG_W-1:0]           cfg_wdata_i,
  output int                                  fail_count_o,
  output int                                  positions_owed_o,
  output int                                  positions_seen_o
);
  import emt_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [ANG_W-1:0]          angle;
    logic signed [MULTI_W-1:0] multi;
    logic signed [POS_W-1:0]   position;
  } position_t;

  position_t owed_positions[$];

  logic [MSTEP_W-1:0]       microsteps;
  logic [STEPS_W-1:0]       steps_per_rev;
  logic signed [OFFS_W-1:0] offset;
  logic [ANG_W-1:0]         held_angle;
  logic [TURN_W-1:0]        turns;

  initial begin
    fail_count_o = 0;
    positions_owed_o = 0;
    positions_seen_o = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic position_t track_position(input logic [RESP_W-1:0] w);
    position_t res;
    logic [ANG_W-1:0] ang;
    int delta;
    logic signed [MULTI_W-1:0] multi;
    logic [MULTI_W-1:0] mag;
    logic [63:0] prod;
    logic [63:0] quo;
    logic signed [63:0] scaled;
    logic signed [63:0] offs;
    if (w[14]) begin
      res.status = STATUS_ERRFLG;
    end else if (w[15] != ^w[14:0]) begin
      res.status = STATUS_PARITY;
    end else begin
      res.status = STATUS_OK;
      ang = {w[13:3], 1'b0};
      delta = int'(ang) - int'(held_angle);
      if (delta < -HALF_REV) begin
        turns = turns + TURN_W'(1);
      end else if (delta > HALF_REV) begin
        turns = turns - TURN_W'(1);
      end
      held_angle = ang;
    end
    multi = {turns, held_angle};
    mag = multi[MULTI_W-1] ? (~multi + MULTI_W'(1)) : multi;
    prod = 64'(mag) * 64'(microsteps) * 64'(steps_per_rev);
    quo = prod / 64'(COUNTS_PER_REV);
    scaled = multi[MULTI_W-1] ? -$signed(quo) : $signed(quo);
    offs = {{(64-OFFS_W){offset[OFFS_W-1]}}, offset};
    res.angle = held_angle;
    res.multi = multi;
    res.position = POS_W'(scaled - offs);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    position_t want;
    if (!rst_ni) begin
      microsteps = MSTEP_RST;
      steps_per_rev = STEPS_RST;
      offset = '0;
      held_angle = '0;
      turns = '0;
      owed_positions.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MICROSTEPS: microsteps = cfg_wdata_i[MSTEP_W-1:0];
          CFG_MOTOR_STEPS: steps_per_rev = cfg_wdata_i[STEPS_W-1:0];
          CFG_OFFSET: offset = cfg_wdata_i[OFFS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        positions_seen_o++;
        if (owed_positions.size() == 0) begin
          report_mismatch("unexpected result", 64'({angle_count_i, status_i}), '0);
        end else begin
          want = owed_positions.pop_front();
          if (status_i !== want.status)
            report_mismatch("status", 64'(status_i), 64'(want.status));
          if (angle_count_i !== want.angle)
            report_mismatch("angle_count", 64'(angle_count_i), 64'(want.angle));
          if (multi_turn_count_i !== want.multi)
            report_mismatch("multi_turn_count", 64'(multi_turn_count_i), 64'(want.multi));
          if (motor_position_i !== want.position)
            report_mismatch("motor_position", 64'(motor_position_i), 64'(want.position));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        owed_positions.push_back(track_position(response_word_i));
      end
    end
    positions_owed_o = owed_positions.size();
  end

endmodule

// ----- verif/tb_encoder_multiturn_position_tracker.sv -----
// Testbench top for the encoder multi-turn position tracker: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_encoder_multiturn_position_tracker;
  import emt_pkg::*;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid;
  logic                        in_stall;
  logic [RESP_W-1:0]           response_word;
  logic                        out_valid;
  logic                        out_stall;
  logic [STAT_W-1:0]           status;
  logic [ANG_W-1:0]            angle_count;
  logic signed [MULTI_W-1:0]   multi_turn_count;
  logic signed [POS_W-1:0]     motor_position;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_idx;
  logic [CFG_W-1:0]            cfg_wdata;

  int  fail_count;
  int  positions_owed;
  int  positions_seen;
  int  words_sent;
  int  stall_left;
  bit  calm;
  int  spin;
  logic [13:0] walk;

  encoder_multiturn_position_tracker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .response_word_i    (response_word),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .status_o           (status),
    .angle_count_o      (angle_count),
    .multi_turn_count_o (multi_turn_count),
    .motor_position_o   (motor_position),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata)
  );

  emt_position_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .response_word_i    (response_word),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .status_i           (status),
    .angle_count_i      (angle_count),
    .multi_turn_count_i (multi_turn_count),
    .motor_position_i   (motor_position),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .fail_count_o       (fail_count),
    .positions_owed_o   (positions_owed),
    .positions_seen_o   (positions_seen)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [RESP_W-1:0] frame(input logic [13:0] ang, input bit err,
                                               input bit good_parity);
    logic [RESP_W-1:0] w;
    w = {1'b0, err, ang};
    w[15] = good_parity ? ^w[14:0] : ~^w[14:0];
    return w;
  endfunction

  function automatic logic [RESP_W-1:0] next_word();
    int r;
    int stride;
    r = $urandom_range(0, 99);
    if (r < 10) return RESP_W'($urandom_range(0, 65535));
    if (r < 20) return frame(14'($urandom), 1'b1, 1'($urandom));
    if (r < 30) return frame(14'($urandom), 1'b0, 1'b0);
    r = $urandom_range(0, 9);
    if (r < 6) begin
      stride = spin * $urandom_range(0, 3000);
    end else if (r < 9) begin
      stride = $urandom_range(0, 16383) - 8192;
    end else begin
      stride = $urandom_range(0, 16383);
    end
    walk = 14'(int'(walk) + stride);
    return frame(walk, 1'b0, 1'b1);
  endfunction

  task automatic send_word(input logic [RESP_W-1:0] w);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid = 1'b0;
    end
    @(negedge clk_i);
    in_valid = 1'b1;
    response_word = w;
    do @(posedge clk_i); while (in_stall);
    words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (positions_owed != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setting(input int phase);
    logic [CFG_W-1:0] rand_offset;
    rand_offset = CFG_W'({$urandom, $urandom});
    case (phase)
      1: begin
        set_reg(CFG_MICROSTEPS, CFG_W'(256));
        set_reg(CFG_MOTOR_STEPS, CFG_W'(1024));
        set_reg(CFG_OFFSET, {1'b0, {(CFG_W-1){1'b1}}});
      end
      2: begin
        set_reg(CFG_MICROSTEPS, CFG_W'(1));
        set_reg(CFG_MOTOR_STEPS, CFG_W'(1));
        set_reg(CFG_OFFSET, {1'b1, {(CFG_W-1){1'b0}}});
      end
      3: begin
        set_reg(CFG_MICROSTEPS, CFG_W'(0));
        set_reg(CFG_MOTOR_STEPS, CFG_W'(2047));
        set_reg(CFG_OFFSET, rand_offset);
      end
      4: begin
        set_reg(CFG_MICROSTEPS, CFG_W'(511));
        set_reg(CFG_MOTOR_STEPS, CFG_W'(0));
        set_reg(CFG_OFFSET, '0);
      end
      default: begin
        set_reg(CFG_MICROSTEPS, CFG_W'($urandom_range(1, 256)));
        set_reg(CFG_MOTOR_STEPS, CFG_W'($urandom_range(1, 1024)));
        set_reg(CFG_OFFSET, rand_offset);
      end
    endcase
  endtask

  always begin
    @(negedge clk_i);
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [RESP_W-1:0] opening[$];
    rst_ni = 1'b0;
    in_valid = 1'b0;
    response_word = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MICROSTEPS;
    cfg_wdata = '0;
    words_sent = 0;
    stall_left = 0;
    calm = 1'b0;
    spin = 1;
    walk = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    opening = '{frame(14'h0000, 1'b0, 1'b1), frame(14'h3FFF, 1'b0, 1'b1),
                frame(14'h0000, 1'b0, 1'b1), frame(14'h2000, 1'b0, 1'b1),
                frame(14'h0000, 1'b0, 1'b1), frame(14'h2008, 1'b0, 1'b1),
                frame(14'h0000, 1'b0, 1'b1), frame(14'h0007, 1'b0, 1'b1),
                frame(14'h1555, 1'b0, 1'b1),
                16'h4000, 16'hC000, 16'hFFFF, 16'h7FFF,
                frame(14'h3FFF, 1'b1, 1'b1), frame(14'h3FFF, 1'b0, 1'b0), 16'h8000, 16'h0001,
                frame(14'h3FFE, 1'b0, 1'b1), frame(14'h1FF8, 1'b0, 1'b1),
                frame(14'h3FF0, 1'b0, 1'b1), frame(14'h1000, 1'b0, 1'b1),
                frame(14'h3FFF, 1'b0, 1'b1), frame(14'h0000, 1'b0, 1'b1)};
    foreach (opening[k]) send_word(opening[k]);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        wait_drained();
        apply_setting(phase);
      end
      calm = (phase == 2);
      spin = $urandom_range(0, 1) ? 1 : -1;
      repeat (75) send_word(next_word());
    end

    wait_drained();
    calm = 1'b0;
    $display("Sent %0d encoder words across six register settings, zero gains and extremes",
             words_sent);
    $display("included; %0d results compared with the predicted positions.", positions_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- encoder_multiturn_position_tracker.f -----
rtl/core/emt_pkg.sv
rtl/core/emt_ctrl.sv
rtl/core/emt_dp.sv
rtl/core/encoder_multiturn_position_tracker.sv
verif/emt_position_checker.sv
verif/tb_encoder_multiturn_position_tracker.sv
